### src/jpp_pkg.sv
`timescale 1ns / 1ps

package jpp_pkg;

    localparam int BYTE_W           = 8;
    localparam int VALUE_W          = 16;
    localparam int PACKET_BYTES_DEF = 128;

    localparam logic [BYTE_W-1:0] CH_START = 8'h53;  // 'S'
    localparam logic [BYTE_W-1:0] CH_END   = 8'h45;  // 'E'
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;  // ','
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;  // '+'
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;  // '-'
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_X_LEAD   = 3'd1,
        PH_X_DIGITS = 3'd2,
        PH_X_DONE   = 3'd3,
        PH_Y_LEAD   = 3'd4,
        PH_Y_DIGITS = 3'd5,
        PH_Y_DONE   = 3'd6
    } t_phase;

endpackage

### src/jpp_byte_if.sv
`timescale 1ns / 1ps

interface jpp_byte_if;
    import jpp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

### src/jpp_result_if.sv
`timescale 1ns / 1ps

interface jpp_result_if;
    import jpp_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      joystick_flag;
    logic signed [VALUE_W-1:0] x_value;
    logic signed [VALUE_W-1:0] y_value;

    modport source (output valid, output joystick_flag, output x_value, output y_value,
                    input ready);
    modport sink   (input valid, input joystick_flag, input x_value, input y_value,
                    output ready);
endinterface

### src/joystick_packet_parser.sv
`timescale 1ns / 1ps

// Joystick packet parser.
// i_byte carries received UART bytes, one byte per handshake. Packets look like
// S<id><any><x>,<y>E; each well-formed packet gives one word on o_result with
// the id flag and the x and y fields, saturated to 16-bit signed.
// Bytes outside a packet, and packets with a NUL byte, no comma, or more than
// PACKET_BYTES-1 bytes, give no word.
// Timing: a byte is captured in the input register and then parsed into the
// packet state and the result register, so a result word is valid once its
// 'E' is parsed. One byte is taken every cycle while o_result does not stall;
// the single pass over the input register and the state is the only stage of work.
// Reset clears the packet state and both registers' valid flags; the parser
// then waits for an 'S'.
// When o_result stalls with a word held, the parse stage stops: one more byte
// is captured in the input register if it was empty, then i_byte.ready drops
// until the held word is taken.
module joystick_packet_parser #(
    parameter int PACKET_BYTES = jpp_pkg::PACKET_BYTES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    jpp_byte_if.sink     i_byte,
    jpp_result_if.source o_result
);
    import jpp_pkg::*;

    localparam int POS_W = $clog2(PACKET_BYTES);
    localparam logic [POS_W-1:0] POS_LAST  = POS_W'(PACKET_BYTES - 1);
    localparam logic [POS_W-1:0] POS_ID    = POS_W'(1);
    localparam logic [POS_W-1:0] POS_FIELD = POS_W'(3);

    function automatic logic is_space(input logic [BYTE_W-1:0] b);
        return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function automatic logic is_digit(input logic [BYTE_W-1:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic [VALUE_W-1:0] accumulate(input logic [VALUE_W-1:0] mag,
                                                      input logic [BYTE_W-1:0] b);
        logic [VALUE_W+3:0] v;
        v = ((VALUE_W+4)'(mag) << 3) + ((VALUE_W+4)'(mag) << 1) + (VALUE_W+4)'(b[3:0]);
        return (v[VALUE_W+3:VALUE_W] != '0) ? {VALUE_W{1'b1}} : v[VALUE_W-1:0];
    endfunction

    function automatic logic signed [VALUE_W-1:0] to_signed(input logic neg,
                                                            input logic [VALUE_W-1:0] mag);
        logic [VALUE_W-1:0] r;
        if (neg) begin
            r = mag[VALUE_W-1] ? {1'b1, {(VALUE_W-1){1'b0}}} : VALUE_W'(0 - mag);
        end else begin
            r = mag[VALUE_W-1] ? {1'b0, {(VALUE_W-1){1'b1}}} : mag;
        end
        return $signed(r);
    endfunction

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;

    logic               r_in_packet, n_in_packet;
    logic [POS_W-1:0]   r_pos, n_pos;
    t_phase             r_phase, n_phase;
    logic               r_id, n_id;
    logic               r_x_neg, n_x_neg;
    logic [VALUE_W-1:0] r_x_mag, n_x_mag;
    logic               r_y_neg, n_y_neg;
    logic [VALUE_W-1:0] r_y_mag, n_y_mag;
    logic               r_zero, n_zero;

    logic                      r_out_valid;
    logic                      r_out_flag;
    logic signed [VALUE_W-1:0] r_out_x;
    logic signed [VALUE_W-1:0] r_out_y;

    logic s2_go;
    logic proc;
    logic emit;

    assign s2_go = !r_out_valid || o_result.ready;
    assign proc  = r_in_valid && s2_go;

    assign i_byte.ready           = !r_in_valid || s2_go;
    assign o_result.valid         = r_out_valid;
    assign o_result.joystick_flag = r_out_flag;
    assign o_result.x_value       = r_out_x;
    assign o_result.y_value       = r_out_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_valid <= i_byte.valid;
        end
        if (i_byte.ready && i_byte.valid) begin
            r_in_byte <= i_byte.rx_byte;
        end
    end

    always_comb begin
        n_in_packet = r_in_packet;
        n_pos       = r_pos;
        n_phase     = r_phase;
        n_id        = r_id;
        n_x_neg     = r_x_neg;
        n_x_mag     = r_x_mag;
        n_y_neg     = r_y_neg;
        n_y_mag     = r_y_mag;
        n_zero      = r_zero;
        emit        = 1'b0;

        if (proc) begin
            priority if (r_in_byte == CH_START) begin
                n_in_packet = 1'b1;
                n_pos       = POS_ID;
                n_phase     = PH_X_LEAD;
                n_id        = 1'b0;
                n_x_neg     = 1'b0;
                n_x_mag     = '0;
                n_y_neg     = 1'b0;
                n_y_mag     = '0;
                n_zero      = 1'b0;
            end else if (!r_in_packet) begin
                // drop bytes outside a packet
            end else if (r_pos >= POS_LAST) begin
                if (r_in_byte == CH_END) begin
                    n_in_packet = 1'b0;
                    n_pos       = '0;
                    n_phase     = PH_IDLE;
                end
            end else if (r_in_byte == CH_END) begin
                emit        = !r_zero && (r_phase == PH_Y_LEAD || r_phase == PH_Y_DIGITS ||
                                          r_phase == PH_Y_DONE);
                n_in_packet = 1'b0;
                n_pos       = '0;
                n_phase     = PH_IDLE;
            end else begin
                n_pos = r_pos + POS_W'(1);
                if (r_in_byte == CH_NUL) begin
                    n_zero = 1'b1;
                end
                if (r_pos == POS_ID) begin
                    n_id = (r_in_byte != CH_ZERO);
                end else if (r_pos >= POS_FIELD) begin
                    unique case (r_phase)
                        PH_X_LEAD: begin
                            priority if (r_in_byte == CH_COMMA) begin
                                n_phase = PH_Y_LEAD;
                            end else if (is_space(r_in_byte)) begin
                                // skip leading whitespace
                            end else if (r_in_byte == CH_PLUS || r_in_byte == CH_MINUS) begin
                                n_x_neg = (r_in_byte == CH_MINUS);
                                n_phase = PH_X_DIGITS;
                            end else if (is_digit(r_in_byte)) begin
                                n_x_mag = accumulate(r_x_mag, r_in_byte);
                                n_phase = PH_X_DIGITS;
                            end else begin
                                n_phase = PH_X_DONE;
                            end
                        end
                        PH_X_DIGITS: begin
                            if (is_digit(r_in_byte)) begin
                                n_x_mag = accumulate(r_x_mag, r_in_byte);
                            end else begin
                                n_phase = (r_in_byte == CH_COMMA) ? PH_Y_LEAD : PH_X_DONE;
                            end
                        end
                        PH_X_DONE: begin
                            if (r_in_byte == CH_COMMA) begin
                                n_phase = PH_Y_LEAD;
                            end
                        end
                        PH_Y_LEAD: begin
                            priority if (is_space(r_in_byte)) begin
                                // skip leading whitespace
                            end else if (r_in_byte == CH_PLUS || r_in_byte == CH_MINUS) begin
                                n_y_neg = (r_in_byte == CH_MINUS);
                                n_phase = PH_Y_DIGITS;
                            end else if (is_digit(r_in_byte)) begin
                                n_y_mag = accumulate(r_y_mag, r_in_byte);
                                n_phase = PH_Y_DIGITS;
                            end else begin
                                n_phase = PH_Y_DONE;
                            end
                        end
                        PH_Y_DIGITS: begin
                            if (is_digit(r_in_byte)) begin
                                n_y_mag = accumulate(r_y_mag, r_in_byte);
                            end else begin
                                n_phase = PH_Y_DONE;
                            end
                        end
                        default: begin
                            // hold: idle or y done
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_packet <= 1'b0;
            r_pos       <= '0;
            r_phase     <= PH_IDLE;
            r_id        <= 1'b0;
            r_x_neg     <= 1'b0;
            r_x_mag     <= '0;
            r_y_neg     <= 1'b0;
            r_y_mag     <= '0;
            r_zero      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_packet <= n_in_packet;
            r_pos       <= n_pos;
            r_phase     <= n_phase;
            r_id        <= n_id;
            r_x_neg     <= n_x_neg;
            r_x_mag     <= n_x_mag;
            r_y_neg     <= n_y_neg;
            r_y_mag     <= n_y_mag;
            r_zero      <= n_zero;
            if (s2_go) begin
                r_out_valid <= emit;
            end
        end
        if (emit) begin
            r_out_flag <= r_id;
            r_out_x    <= to_signed(r_x_neg, r_x_mag);
            r_out_y    <= to_signed(r_y_neg, r_y_mag);
        end
    end

endmodule

### tb/joystick_packet_parser_test.sv
`timescale 1ns / 1ps

module joystick_packet_parser_test;
    import jpp_pkg::*;

    localparam int PKT_BYTES   = PACKET_BYTES_DEF;
    localparam int RANDOM_USED = 700;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic                      flag;
        logic signed [VALUE_W-1:0] x;
        logic signed [VALUE_W-1:0] y;
    } t_report;

    logic clk;
    logic rst_n;

    jpp_byte_if   byte_bus ();
    jpp_result_if result_bus ();

    joystick_packet_parser #(.PACKET_BYTES(PKT_BYTES)) dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_byte   (byte_bus),
        .o_result (result_bus)
    );

    // Parser mirror
    bit                 in_pkt;
    int unsigned        pos;
    t_phase             phase;
    bit                 id_flag;
    bit                 x_neg;
    bit                 y_neg;
    logic [VALUE_W-1:0] x_mag;
    logic [VALUE_W-1:0] y_mag;
    bit                 nul_seen;

    t_report           pending_reports[$];
    logic [BYTE_W-1:0] frame[$];

    int  errors;
    int  bytes_sent;
    int  bytes_parsed;
    int  reports_made;
    int  reports_checked;
    int  cycles;
    bit  steady;

    string edge_nums[8] = '{"32767", "32768", "65535", "65536", "99999",
                            "0", "000032767", "1000000"};

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("FAIL joystick_packet_parser");
        $finish;
    end

    function automatic bit is_space(logic [BYTE_W-1:0] b);
        return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function automatic bit is_digit(logic [BYTE_W-1:0] b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    // Accumulate one decimal digit, saturate at 16 bits unsigned.
    function automatic logic [VALUE_W-1:0] push_digit(logic [VALUE_W-1:0] m,
                                                      logic [BYTE_W-1:0] b);
        int v;
        v = int'(m) * 10 + int'(b) - int'(CH_ZERO);
        return (v > 65535) ? 16'hFFFF : v[VALUE_W-1:0];
    endfunction

    function automatic logic signed [VALUE_W-1:0] clamp16(bit neg, logic [VALUE_W-1:0] m);
        if (neg)
            return (m >= 16'h8000) ? 16'sh8000 : -$signed(m);
        return (m > 16'h7FFF) ? 16'sh7FFF : $signed(m);
    endfunction

    function automatic void parse_field(logic [BYTE_W-1:0] b);
        case (phase)
            PH_X_LEAD: begin
                if (b == CH_COMMA) phase = PH_Y_LEAD;
                else if (is_space(b)) ;
                else if (b == CH_PLUS || b == CH_MINUS) begin
                    x_neg = (b == CH_MINUS);
                    phase = PH_X_DIGITS;
                end else if (is_digit(b)) begin
                    x_mag = push_digit(x_mag, b);
                    phase = PH_X_DIGITS;
                end else phase = PH_X_DONE;
            end
            PH_X_DIGITS: begin
                if (is_digit(b)) x_mag = push_digit(x_mag, b);
                else phase = (b == CH_COMMA) ? PH_Y_LEAD : PH_X_DONE;
            end
            PH_X_DONE: begin
                if (b == CH_COMMA) phase = PH_Y_LEAD;
            end
            PH_Y_LEAD: begin
                if (is_space(b)) ;
                else if (b == CH_PLUS || b == CH_MINUS) begin
                    y_neg = (b == CH_MINUS);
                    phase = PH_Y_DIGITS;
                end else if (is_digit(b)) begin
                    y_mag = push_digit(y_mag, b);
                    phase = PH_Y_DIGITS;
                end else phase = PH_Y_DONE;
            end
            PH_Y_DIGITS: begin
                if (is_digit(b)) y_mag = push_digit(y_mag, b);
                else phase = PH_Y_DONE;
            end
            default: ;
        endcase
    endfunction

    function automatic void clear_parser();
        in_pkt   = 1'b0;
        pos      = 0;
        phase    = PH_IDLE;
        id_flag  = 1'b0;
        x_neg    = 1'b0;
        y_neg    = 1'b0;
        x_mag    = '0;
        y_mag    = '0;
        nul_seen = 1'b0;
    endfunction

    // Advance the mirror by one byte; return 1 if the byte did any work.
    function automatic bit parse_byte(logic [BYTE_W-1:0] b);
        t_report r;
        if (b == CH_START) begin
            clear_parser();
            in_pkt = 1'b1;
            pos    = 1;
            phase  = PH_X_LEAD;
            return 1'b1;
        end
        if (!in_pkt)
            return 1'b0;
        if (pos >= PKT_BYTES - 1) begin
            if (b == CH_END) begin
                in_pkt = 1'b0;
                pos    = 0;
                phase  = PH_IDLE;
            end
            return 1'b0;
        end
        if (b == CH_END) begin
            if (!nul_seen && phase >= PH_Y_LEAD) begin
                r.flag = id_flag;
                r.x    = clamp16(x_neg, x_mag);
                r.y    = clamp16(y_neg, y_mag);
                pending_reports.push_back(r);
                reports_made++;
            end
            in_pkt = 1'b0;
            pos    = 0;
            phase  = PH_IDLE;
            return 1'b1;
        end
        if (b == CH_NUL)
            nul_seen = 1'b1;
        if (pos == 1)
            id_flag = (b != CH_ZERO);
        else if (pos >= 3)
            parse_field(b);
        pos++;
        return 1'b1;
    endfunction

    // Result side: random stalls, compare each word with the oldest report.
    initial begin
        int      stall;
        t_report want;
        stall = 0;
        result_bus.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && result_bus.valid && result_bus.ready) begin
                reports_checked++;
                if (pending_reports.size() == 0) begin
                    $error("result word with no report pending: flag %0d x %0d y %0d",
                           result_bus.joystick_flag, result_bus.x_value, result_bus.y_value);
                    errors++;
                end else begin
                    want = pending_reports.pop_front();
                    if (result_bus.joystick_flag !== want.flag) begin
                        $error("joystick_flag: expected %0d, got %0d",
                               want.flag, result_bus.joystick_flag);
                        errors++;
                    end
                    if (result_bus.x_value !== want.x) begin
                        $error("x_value: expected %0d, got %0d", want.x, result_bus.x_value);
                        errors++;
                    end
                    if (result_bus.y_value !== want.y) begin
                        $error("y_value: expected %0d, got %0d", want.y, result_bus.y_value);
                        errors++;
                    end
                end
                stall = steady ? 0 : $urandom_range(0, 4);
            end else if (stall > 0) begin
                stall--;
            end
            result_bus.ready <= (stall == 0);
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            byte_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_bus.valid   <= 1'b1;
        byte_bus.rx_byte <= b;
        @(posedge clk);
        while (!byte_bus.ready) @(posedge clk);
        bytes_sent++;
        if (parse_byte(b))
            bytes_parsed++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_frame();
        foreach (frame[i])
            send_byte(frame[i]);
        frame.delete();
    endtask

    // Drop valid so the last word is not taken again, then wait for every report.
    task automatic wait_drained();
        byte_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending_reports.size() != 0) @(posedge clk);
    endtask

    function automatic logic [BYTE_W-1:0] filler();
        logic [BYTE_W-1:0] b;
        do b = BYTE_W'($urandom_range(0, 255));
        while (b == CH_START || b == CH_END);
        return b;
    endfunction

    // Push an atoi-style number: whitespace, optional sign, digits, maybe junk.
    function automatic void add_number();
        int    n_ws;
        int    n_dig;
        int    pick;
        int    sgn;
        string s;
        n_ws = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        for (int i = 0; i < n_ws; i++) begin
            pick = $urandom_range(0, 5);
            frame.push_back((pick < 5) ? BYTE_W'(CH_TAB + pick) : CH_SPACE);
        end
        sgn = $urandom_range(0, 3);
        if (sgn == 2) frame.push_back(CH_PLUS);
        if (sgn == 3) frame.push_back(CH_MINUS);
        if ($urandom_range(0, 7) == 0) begin
            s = edge_nums[$urandom_range(0, 7)];
            for (int i = 0; i < s.len(); i++)
                frame.push_back(s[i]);
        end else begin
            n_dig = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(4, 7);
            for (int i = 0; i < n_dig; i++)
                frame.push_back(BYTE_W'($urandom_range(CH_ZERO, CH_NINE)));
        end
        if ($urandom_range(0, 7) == 0)
            frame.push_back(filler());
    endfunction

    function automatic void add_head();
        frame.push_back(CH_START);
        frame.push_back(($urandom_range(0, 2) == 0) ? CH_ZERO : filler());
        frame.push_back(filler());
    endfunction

    task automatic test_directed();
        send_byte(8'hFF);
        send_byte(CH_END);
        send_text("SE");
        send_text("S1 ,E");
        send_text("S0");
        send_byte(CH_NUL);
        send_text(",E");
        send_text("S0:+,-E");
        send_text("S1a-12,+345E");
        wait_drained();
    endtask

    task automatic test_random_packets();
        int start_used;
        int kind;
        int pkts;
        start_used = bytes_sent;
        pkts = 0;
        while (bytes_sent - start_used < RANDOM_USED) begin
            if (pkts % 20 == 0)
                steady = ($urandom_range(0, 5) == 0);
            if (pkts % 60 == 59)
                wait_drained();
            kind = $urandom_range(0, 99);
            if (kind < 64) begin
                add_head();
                add_number();
                frame.push_back(CH_COMMA);
                add_number();
                frame.push_back(CH_END);
            end else if (kind < 72) begin
                // no comma: drop at the end byte
                add_head();
                add_number();
                frame.push_back(CH_END);
            end else if (kind < 78) begin
                add_head();
                add_number();
                frame.push_back(CH_COMMA);
                add_number();
                frame.insert($urandom_range(1, frame.size() - 1), CH_NUL);
                frame.push_back(CH_END);
            end else if (kind < 84) begin
                // cut short; the next start byte restarts the parse
                add_head();
                add_number();
                frame.push_back(CH_COMMA);
                add_number();
            end else if (kind < 92) begin
                repeat ($urandom_range(1, 6))
                    frame.push_back(BYTE_W'($urandom_range(0, 255)));
            end else begin
                frame.push_back(CH_START);
                repeat ($urandom_range(0, 4))
                    frame.push_back(($urandom_range(0, 1) == 0) ? CH_COMMA : filler());
                frame.push_back(CH_END);
            end
            send_frame();
            pkts++;
        end
        steady = 1'b0;
    endtask

    // Packets around the buffer limit: the last one that still reports and beyond.
    task automatic test_buffer_limit();
        int lens[5] = '{125, 126, 127, 128, 150};
        wait_drained();
        foreach (lens[k]) begin
            steady = (k == 1);
            frame.push_back(CH_START);
            frame.push_back(CH_ZERO);
            frame.push_back(8'h61);
            frame.push_back(CH_MINUS);
            frame.push_back(8'h37);
            frame.push_back(CH_COMMA);
            frame.push_back(8'h32);
            while (frame.size() < lens[k])
                frame.push_back(8'h7A);
            frame.push_back(CH_END);
            send_frame();
        end
        steady = 1'b0;
    endtask

    initial begin
        errors          = 0;
        bytes_sent      = 0;
        bytes_parsed    = 0;
        reports_made    = 0;
        reports_checked = 0;
        steady          = 1'b0;
        clear_parser();
        rst_n            <= 1'b0;
        byte_bus.valid   <= 1'b0;
        byte_bus.rx_byte <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_packets();
        test_buffer_limit();

        wait_drained();
        repeat (10) @(posedge clk);

        $display("Sent %0d bytes (%0d parsed) in directed, random and buffer-limit packets;",
                 bytes_sent, bytes_parsed);
        $display("%0d reports predicted, %0d result words checked.",
                 reports_made, reports_checked);
        if (errors == 0 && pending_reports.size() == 0) begin
            $display("PASS joystick_packet_parser");
        end else begin
            $display("FAIL joystick_packet_parser");
        end
        $finish;
    end

endmodule
